// File: hdl/sorb_pkg.sv
`timescale 1ns / 1ps

package sorb_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int SEQ_BITS     = 8;
    localparam int TAG_BITS     = 16;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int ENT_W = SEQ_BITS + TAG_BITS;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [1:0]          status;
        logic [SEQ_BITS-1:0] seq_number;
        logic [TAG_BITS-1:0] packet_tag;
        logic [CNT_W-1:0]    fill_count;
    } t_res;

    // physical slot of logical position off, counted from head, wrapping once
    function automatic logic [IDX_W-1:0] phys_slot(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(BUFFER_DEPTH)) begin
            sum = sum - (IDX_W + 1)'(BUFFER_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: hdl/sorb_ram.sv
`timescale 1ns / 1ps

module sorb_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/sorb_ctrl.sv
`timescale 1ns / 1ps

module sorb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_cmd,
    input  logic [sorb_pkg::SEQ_BITS-1:0] i_seq_number,
    input  logic [sorb_pkg::TAG_BITS-1:0] i_packet_tag,
    output logic                          o_busy,
    output sorb_pkg::t_res                o_res,
    input  logic                          i_res_ready,
    output logic                          o_wr_en,
    output logic [sorb_pkg::IDX_W-1:0]    o_wr_addr,
    output logic [sorb_pkg::ENT_W-1:0]    o_wr_data,
    output logic                          o_rd_en,
    output logic [sorb_pkg::IDX_W-1:0]    o_rd_addr,
    input  logic [sorb_pkg::ENT_W-1:0]    i_rd_data
);

    import sorb_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_SHRD  = 4'd3;
    localparam logic [3:0] S_SHWR  = 4'd4;
    localparam logic [3:0] S_WRNEW = 4'd5;
    localparam logic [3:0] S_POPRD = 4'd6;
    localparam logic [3:0] S_POPDT = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [SEQ_BITS-1:0] r_seq, n_seq;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [1:0]          r_status, n_status;
    logic [SEQ_BITS-1:0] r_oseq, n_oseq;
    logic [TAG_BITS-1:0] r_otag, n_otag;

    logic [SEQ_BITS-1:0] rd_seq;
    logic [CNT_W-1:0]    idx_m1;

    assign rd_seq = i_rd_data[ENT_W-1:TAG_BITS];
    assign idx_m1 = r_idx - CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_seq    = r_seq;
        n_tag    = r_tag;
        n_count  = r_count;
        n_head   = r_head;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_status = r_status;
        n_oseq   = r_oseq;
        n_otag   = r_otag;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = '0;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_seq    = i_seq_number;
                    n_tag    = i_packet_tag;
                    n_status = ST_OK;
                    n_oseq   = '0;
                    n_otag   = '0;
                    n_idx    = '0;
                    n_pos    = r_count;
                    case (i_cmd) inside
                        CMD_APPEND, CMD_INSERT: begin
                            if (r_count == CNT_W'(BUFFER_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (i_cmd == CMD_APPEND) begin
                                n_state = S_WRNEW;
                            end else begin
                                n_state = S_SRD;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_POPRD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (r_idx == r_count) begin
                    // nothing at or above the new number: goes at the tail
                    n_pos   = r_count;
                    n_state = S_WRNEW;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = phys_slot(r_head, r_idx[IDX_W-1:0]);
                    n_state   = S_SCMP;
                end
            end
            S_SCMP: begin
                if (rd_seq >= r_seq) begin
                    if (rd_seq == r_seq) begin
                        n_status = ST_DUP;
                        n_state  = S_DONE;
                    end else begin
                        n_pos   = r_idx;
                        n_idx   = r_count;
                        n_state = S_SHRD;
                    end
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_SRD;
                end
            end
            S_SHRD: begin
                // move entries one slot toward the tail, last first
                if (r_idx == r_pos) begin
                    n_state = S_WRNEW;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = phys_slot(r_head, idx_m1[IDX_W-1:0]);
                    n_state   = S_SHWR;
                end
            end
            S_SHWR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = phys_slot(r_head, r_idx[IDX_W-1:0]);
                o_wr_data = i_rd_data;
                n_idx     = idx_m1;
                n_state   = S_SHRD;
            end
            S_WRNEW: begin
                o_wr_en   = 1'b1;
                o_wr_addr = phys_slot(r_head, r_pos[IDX_W-1:0]);
                o_wr_data = {r_seq, r_tag};
                n_count   = r_count + CNT_W'(1);
                n_state   = S_DONE;
            end
            S_POPRD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_head;
                n_state   = S_POPDT;
            end
            S_POPDT: begin
                n_oseq  = rd_seq;
                n_otag  = i_rd_data[TAG_BITS-1:0];
                n_head  = phys_slot(r_head, IDX_W'(1));
                n_count = r_count - CNT_W'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq    <= n_seq;
        r_tag    <= n_tag;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_oseq   <= n_oseq;
        r_otag   <= n_otag;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_res.valid      = (r_state == S_DONE);
    assign o_res.status     = r_status;
    assign o_res.seq_number = r_oseq;
    assign o_res.packet_tag = r_otag;
    assign o_res.fill_count = r_count;

endmodule

// File: hdl/sorted_reorder_buffer_top.sv
`timescale 1ns / 1ps

// from input transfer to result in the output register: unused code, full and empty go
// straight to the result, append writes the new entry, pop reads the head, insert reads and
// compares entries from the head, ends at a duplicate, else moves the later ones one slot
// toward the tail and writes; reads use the single registered read port of the entry store
// one item at a time: the next transfer is taken the cycle after the result is registered
// reset (synchronous, active low) empties the buffer; entry contents are not cleared

module sorted_reorder_buffer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [sorb_pkg::SEQ_BITS-1:0] i_seq_number,
    input  logic [sorb_pkg::TAG_BITS-1:0] i_packet_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [sorb_pkg::SEQ_BITS-1:0] o_out_seq_number,
    output logic [sorb_pkg::TAG_BITS-1:0] o_out_packet_tag,
    output logic [sorb_pkg::CNT_W-1:0]    o_fill_count
);

    import sorb_pkg::*;

    logic             busy;
    logic             start;
    t_res             res;
    logic             res_ready;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [SEQ_BITS-1:0] r_oseq;
    logic [TAG_BITS-1:0] r_otag;
    logic [CNT_W-1:0]    r_fill;

    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;
    assign res_ready  = !r_out_valid || !i_out_stall;

    sorb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_seq_number (i_seq_number),
        .i_packet_tag (i_packet_tag),
        .o_busy       (busy),
        .o_res        (res),
        .i_res_ready  (res_ready),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    sorb_ram #(
        .DEPTH (BUFFER_DEPTH),
        .WIDTH (ENT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register, loaded when empty or being drained by a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_status <= res.status;
            r_oseq   <= res.seq_number;
            r_otag   <= res.packet_tag;
            r_fill   <= res.fill_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_out_seq_number = r_oseq;
    assign o_out_packet_tag = r_otag;
    assign o_fill_count     = r_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fill_count <= CNT_W'(BUFFER_DEPTH)))
        else $error("fill count beyond buffer depth");

    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_fill_count == '0))
        else $error("empty status with entries held");

    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_fill_count == CNT_W'(BUFFER_DEPTH)))
        else $error("full status with free slots");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again before the item finished");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sorb_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [1:0]          status;
        logic [SEQ_BITS-1:0] seq_number;
        logic [TAG_BITS-1:0] packet_tag;
        logic [CNT_W-1:0]    fill_count;
    } t_buffer_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_cmd;
    logic [SEQ_BITS-1:0] i_seq_number;
    logic [TAG_BITS-1:0] i_packet_tag;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [1:0]          o_status;
    logic [SEQ_BITS-1:0] o_out_seq_number;
    logic [TAG_BITS-1:0] o_out_packet_tag;
    logic [CNT_W-1:0]    o_fill_count;

    // shadow copy of the buffer, updated on every input transfer
    logic [SEQ_BITS-1:0] shadow_seq [BUFFER_DEPTH];
    logic [TAG_BITS-1:0] shadow_tag [BUFFER_DEPTH];
    int                  shadow_fill;

    t_buffer_outcome outcome_q [$];
    int              fail_count;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              quiet_cycles;

    sorted_reorder_buffer_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_seq_number     (i_seq_number),
        .i_packet_tag     (i_packet_tag),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_out_seq_number (o_out_seq_number),
        .o_out_packet_tag (o_out_packet_tag),
        .o_fill_count     (o_fill_count)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    task automatic apply_buffer_cmd(input logic [1:0] cmd, input logic [SEQ_BITS-1:0] seq,
                                    input logic [TAG_BITS-1:0] tag);
        t_buffer_outcome res;
        int pos;
        res.status = ST_OK;
        res.seq_number = '0;
        res.packet_tag = '0;
        if (cmd == CMD_APPEND || cmd == CMD_INSERT) begin
            if (shadow_fill >= BUFFER_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = shadow_fill;
                if (cmd == CMD_INSERT) begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        if (shadow_seq[i] >= seq) begin
                            pos = i;
                            break;
                        end
                    end
                end
                if (cmd == CMD_INSERT && pos < shadow_fill && shadow_seq[pos] == seq) begin
                    res.status = ST_DUP;
                end else begin
                    for (int i = shadow_fill; i > pos; i--) begin
                        shadow_seq[i] = shadow_seq[i-1];
                        shadow_tag[i] = shadow_tag[i-1];
                    end
                    shadow_seq[pos] = seq;
                    shadow_tag[pos] = tag;
                    shadow_fill++;
                end
            end
        end else if (cmd == CMD_POP) begin
            if (shadow_fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.seq_number = shadow_seq[0];
                res.packet_tag = shadow_tag[0];
                for (int i = 1; i < shadow_fill; i++) begin
                    shadow_seq[i-1] = shadow_seq[i];
                    shadow_tag[i-1] = shadow_tag[i];
                end
                shadow_fill--;
            end
        end
        res.fill_count = CNT_W'(shadow_fill);
        outcome_q.push_back(res);
    endtask

    // holds valid high from the step of the previous transfer unless an idle gap is drawn
    task automatic send_item(input logic [1:0] cmd, input logic [SEQ_BITS-1:0] seq,
                             input logic [TAG_BITS-1:0] tag);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid   <= 1'b0;
            i_cmd        <= 2'($urandom);
            i_seq_number <= SEQ_BITS'($urandom);
            i_packet_tag <= TAG_BITS'($urandom);
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_seq_number <= seq;
        i_packet_tag <= tag;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        apply_buffer_cmd(cmd, seq, tag);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (outcome_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // biased towards numbers already held so that duplicates turn up often
    function automatic logic [SEQ_BITS-1:0] pick_seq();
        if (shadow_fill > 0 && $urandom_range(0, 99) < 30) begin
            return shadow_seq[$urandom_range(0, shadow_fill - 1)];
        end
        return SEQ_BITS'($urandom);
    endfunction

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 15);
        if (r < 6) begin
            return CMD_INSERT;
        end else if (r < 9) begin
            return CMD_APPEND;
        end else if (r < 15) begin
            return CMD_POP;
        end
        return CMD_NOP;
    endfunction

    task automatic test_directed_cases();
        send_item(CMD_POP, 8'hFF, 16'hFFFF);
        send_item(CMD_NOP, 8'hAA, 16'h5555);
        send_item(CMD_INSERT, 8'h80, 16'hFFFF);
        send_item(CMD_INSERT, 8'h00, 16'h0000);
        send_item(CMD_INSERT, 8'hFF, 16'hA5A5);
        send_item(CMD_INSERT, 8'h40, 16'h5A5A);
        send_item(CMD_INSERT, 8'h80, 16'h1111);
        send_item(CMD_INSERT, 8'h00, 16'h2222);
        send_item(CMD_INSERT, 8'hFF, 16'h3333);
        send_item(CMD_APPEND, 8'h10, 16'h1234);
        send_item(CMD_APPEND, 8'h80, 16'h8001);
        send_item(CMD_INSERT, 8'h20, 16'h7FFE);
        send_item(CMD_NOP, 8'h55, 16'hAAAA);
        for (int i = 0; i < 8; i++) begin
            send_item(CMD_POP, SEQ_BITS'($urandom), TAG_BITS'($urandom));
        end
        send_item(CMD_NOP, 8'h00, 16'h0000);
        wait_drained();
    endtask

    task automatic test_full_store();
        while (shadow_fill < BUFFER_DEPTH) begin
            send_item(CMD_INSERT, SEQ_BITS'($urandom), TAG_BITS'($urandom));
        end
        send_item(CMD_APPEND, SEQ_BITS'($urandom), TAG_BITS'($urandom));
        send_item(CMD_INSERT, SEQ_BITS'($urandom), TAG_BITS'($urandom));
        // a duplicate offered to a full store reports full
        send_item(CMD_INSERT, shadow_seq[$urandom_range(0, BUFFER_DEPTH - 1)],
                  TAG_BITS'($urandom));
        send_item(CMD_POP, SEQ_BITS'($urandom), TAG_BITS'($urandom));
        send_item(CMD_APPEND, SEQ_BITS'($urandom), TAG_BITS'($urandom));
        send_item(CMD_INSERT, pick_seq(), TAG_BITS'($urandom));
        while (shadow_fill > 0) begin
            send_item(CMD_POP, SEQ_BITS'($urandom), TAG_BITS'($urandom));
        end
        send_item(CMD_POP, SEQ_BITS'($urandom), TAG_BITS'($urandom));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int kind;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                // fill towards full, a few past it
                burst = BUFFER_DEPTH - shadow_fill + $urandom_range(0, 3);
                for (int i = 0; i < burst; i++) begin
                    send_item(($urandom_range(0, 4) == 0) ? CMD_APPEND : CMD_INSERT,
                              pick_seq(), TAG_BITS'($urandom));
                    sent++;
                end
            end else if (kind < 7) begin
                burst = shadow_fill + $urandom_range(0, 2);
                for (int i = 0; i < burst; i++) begin
                    send_item(CMD_POP, SEQ_BITS'($urandom), TAG_BITS'($urandom));
                    sent++;
                end
            end else begin
                burst = $urandom_range(8, 24);
                for (int i = 0; i < burst; i++) begin
                    send_item(pick_cmd(), pick_seq(), TAG_BITS'($urandom));
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_buffer_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                $error("result transfer with nothing expected: status %0d fill %0d",
                       o_status, o_fill_count);
                fail_count++;
            end else begin
                want = outcome_q.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_out_seq_number !== want.seq_number) begin
                    $error("out_seq_number: expected %0h, actual %0h",
                           want.seq_number, o_out_seq_number);
                    fail_count++;
                end
                if (o_out_packet_tag !== want.packet_tag) begin
                    $error("out_packet_tag: expected %0h, actual %0h",
                           want.packet_tag, o_out_packet_tag);
                    fail_count++;
                end
                if (o_fill_count !== want.fill_count) begin
                    $error("fill_count: expected %0d, actual %0d",
                           want.fill_count, o_fill_count);
                    fail_count++;
                end
            end
        end
    end

    // counts cycles without any transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_cmd         <= CMD_NOP;
        i_seq_number  <= '0;
        i_packet_tag  <= '0;
        fail_count    = 0;
        shadow_fill   = 0;
        send_idle_pct = 35;
        recv_idle_pct = 76;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_full_store();
        test_random_traffic(280);
        send_idle_pct = 76;
        recv_idle_pct = 35;
        test_random_traffic(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            $error("%0d expected results never arrived", outcome_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/sorb_pkg.sv
hdl/sorb_ram.sv
hdl/sorb_ctrl.sv
hdl/sorted_reorder_buffer_top.sv
tb/testbench.sv
